@@ rtl/gipw_pkg.sv @@
// ----------------------------------------------------------------------------
// gipw_pkg
// Shared types and constants of the interlaced GIF pixel writer.
// ----------------------------------------------------------------------------
package gipw_pkg;

  localparam int CFG_W       = 16;  // widest configuration register
  localparam int CFG_IDX_W   = 3;
  localparam int PIX_W       = 8;
  localparam int OUT_ADDR_W  = 32;
  localparam int OUT_ROW_W   = 16;
  localparam int PASS_W      = 3;

  localparam int COORD_BITS_DEF = 16;
  localparam int ADDR_BITS_DEF  = 32;

  // Request kinds on the input channel
  localparam logic MODE_START = 1'b0;
  localparam logic MODE_PIXEL = 1'b1;

  // Row order passes: 0 is progressive, 1 to 4 are the interlace passes
  localparam logic [PASS_W-1:0] PASS_NORMAL = 3'd0;
  localparam logic [PASS_W-1:0] PASS_1      = 3'd1;
  localparam logic [PASS_W-1:0] PASS_2      = 3'd2;
  localparam logic [PASS_W-1:0] PASS_3      = 3'd3;
  localparam logic [PASS_W-1:0] PASS_4      = 3'd4;

  localparam int ROW_STEP_NORMAL = 1;
  localparam int ROW_STEP_P1     = 8;
  localparam int ROW_STEP_P2     = 8;
  localparam int ROW_STEP_P3     = 4;
  localparam int ROW_STEP_P4     = 2;

  // First row of a pass, relative to the sub-image top
  localparam int ROW_START_P2 = 4;
  localparam int ROW_START_P3 = 2;
  localparam int ROW_START_P4 = 1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH         = 3'd0,
    REG_FRAME_WIDTH         = 3'd1,
    REG_FRAME_HEIGHT        = 3'd2,
    REG_OFFSET_X            = 3'd3,
    REG_OFFSET_Y            = 3'd4,
    REG_INTERLACED          = 3'd5,
    REG_TRANSPARENCY_ENABLE = 3'd6,
    REG_TRANSPARENT_INDEX   = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic [CFG_W-1:0] image_width;
    logic [CFG_W-1:0] frame_width;
    logic [CFG_W-1:0] frame_height;
    logic [CFG_W-1:0] offset_x;
    logic [CFG_W-1:0] offset_y;
    logic             interlaced;
    logic             transparency_enable;
    logic [PIX_W-1:0] transparent_index;
  } cfg_t;

  // Per-request control carried down the address pipeline
  typedef struct packed {
    logic             start;
    logic             we;
    logic [PIX_W-1:0] data;
    logic             done;
    logic             zero_base;
  } item_ctl_t;

endpackage

@@ rtl/gipw_if.sv @@
// ----------------------------------------------------------------------------
// gipw_in_if / gipw_out_if
// Valid/ready channels of the pixel writer.
// ----------------------------------------------------------------------------
interface gipw_in_if;
  logic                      valid;
  logic                      ready;
  logic                      mode;
  logic [gipw_pkg::PIX_W-1:0] pixel_index;

  modport source (output valid, mode, pixel_index, input ready);
  modport sink   (input valid, mode, pixel_index, output ready);
endinterface

interface gipw_out_if;
  logic                            valid;
  logic                            ready;
  logic                            write_enable;
  logic [gipw_pkg::OUT_ADDR_W-1:0] write_address;
  logic [gipw_pkg::PIX_W-1:0]      write_data;
  logic                            row_done;
  logic [gipw_pkg::OUT_ROW_W-1:0]  row_number;

  modport source (output valid, write_enable, write_address, write_data, row_done,
                  row_number, input ready);
  modport sink   (input valid, write_enable, write_address, write_data, row_done,
                  row_number, output ready);
endinterface

@@ rtl/gipw_cfg.sv @@
// ----------------------------------------------------------------------------
// gipw_cfg
// Configuration register bank, write-only.
// ----------------------------------------------------------------------------
module gipw_cfg (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [gipw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gipw_pkg::CFG_W-1:0]     cfg_wdata,
  output gipw_pkg::cfg_t                 cfg
);

  gipw_pkg::cfg_t cfg_r, cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (gipw_pkg::cfg_reg_t'(cfg_index))
        gipw_pkg::REG_IMAGE_WIDTH:         cfg_nxt.image_width = cfg_wdata;
        gipw_pkg::REG_FRAME_WIDTH:         cfg_nxt.frame_width = cfg_wdata;
        gipw_pkg::REG_FRAME_HEIGHT:        cfg_nxt.frame_height = cfg_wdata;
        gipw_pkg::REG_OFFSET_X:            cfg_nxt.offset_x = cfg_wdata;
        gipw_pkg::REG_OFFSET_Y:            cfg_nxt.offset_y = cfg_wdata;
        gipw_pkg::REG_INTERLACED:          cfg_nxt.interlaced = cfg_wdata[0];
        gipw_pkg::REG_TRANSPARENCY_ENABLE: cfg_nxt.transparency_enable = cfg_wdata[0];
        gipw_pkg::REG_TRANSPARENT_INDEX:
          cfg_nxt.transparent_index = cfg_wdata[gipw_pkg::PIX_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{image_width:         gipw_pkg::CFG_W'(1),
                 frame_width:         gipw_pkg::CFG_W'(1),
                 frame_height:        gipw_pkg::CFG_W'(1),
                 offset_x:            '0,
                 offset_y:            '0,
                 interlaced:          1'b0,
                 transparency_enable: 1'b0,
                 transparent_index:   '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

@@ rtl/gipw_pos.sv @@
// ----------------------------------------------------------------------------
// gipw_pos
// Position tracker: row, pass, pixel count and column, plus input register.
// ----------------------------------------------------------------------------
module gipw_pos #(
  parameter int COORD_BITS = gipw_pkg::COORD_BITS_DEF,
  parameter int ADDR_BITS  = gipw_pkg::ADDR_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  gipw_pkg::cfg_t               cfg,
  input  logic                         in_valid,
  input  logic                         in_mode,
  input  logic [gipw_pkg::PIX_W-1:0]   in_pixel,
  output logic                         in_ready,
  input  logic                         take,
  output logic                         s1_valid,
  output gipw_pkg::item_ctl_t          s1_ctl,
  output logic [COORD_BITS-1:0]        s1_row,
  output logic [ADDR_BITS-1:0]         s1_col,
  output logic [gipw_pkg::CFG_W-1:0]   s1_fw,
  output logic [gipw_pkg::CFG_W-1:0]   s1_ox
);

  // row sums are compared against frame_height one bit wider than a register
  localparam int RW = gipw_pkg::CFG_W + 1;

  logic [gipw_pkg::CFG_W-1:0]  pixels_left_r, pixels_left_nxt;
  logic [COORD_BITS-1:0]       row_r, row_nxt;
  logic [gipw_pkg::PASS_W-1:0] pass_r, pass_nxt;
  logic [ADDR_BITS-1:0]        col_r, col_nxt;
  logic                        zero_base_r, zero_base_nxt;
  // row base terms, taken when the row begins
  logic [gipw_pkg::CFG_W-1:0]  fw_r, fw_nxt, ox_r, ox_nxt;

  logic                        v1_r, v1_nxt;
  gipw_pkg::item_ctl_t         ctl1_r, ctl_in;
  logic [COORD_BITS-1:0]       row1_r;
  logic [ADDR_BITS-1:0]        col1_r;
  logic [gipw_pkg::CFG_W-1:0]  fw1_r, ox1_r;

  logic                        en1, accept, done;
  logic [RW-1:0]               step, r_sum;
  logic [gipw_pkg::PASS_W-1:0] p_step;

  assign en1      = !v1_r || take;
  assign accept   = in_valid && en1;
  assign in_ready = en1;
  assign done     = (pixels_left_r <= gipw_pkg::CFG_W'(1));

  // Next row at end of row; a pass that runs off the frame hands over to the
  // next one, possibly several in a row for short frames.
  always_comb begin
    case (pass_r)
      gipw_pkg::PASS_NORMAL: step = RW'(gipw_pkg::ROW_STEP_NORMAL);
      gipw_pkg::PASS_1:      step = RW'(gipw_pkg::ROW_STEP_P1);
      gipw_pkg::PASS_2:      step = RW'(gipw_pkg::ROW_STEP_P2);
      gipw_pkg::PASS_3:      step = RW'(gipw_pkg::ROW_STEP_P3);
      gipw_pkg::PASS_4:      step = RW'(gipw_pkg::ROW_STEP_P4);
      default:               step = '0;
    endcase
    r_sum  = RW'(row_r) + step;
    p_step = pass_r;
    for (int i = 0; i < 3; i++) begin
      if (p_step >= gipw_pkg::PASS_1 && p_step <= gipw_pkg::PASS_3 &&
          r_sum >= RW'(cfg.frame_height)) begin
        p_step = p_step + 1'b1;
        case (p_step)
          gipw_pkg::PASS_2: r_sum = RW'(cfg.offset_y) + RW'(gipw_pkg::ROW_START_P2);
          gipw_pkg::PASS_3: r_sum = RW'(cfg.offset_y) + RW'(gipw_pkg::ROW_START_P3);
          default:          r_sum = RW'(cfg.offset_y) + RW'(gipw_pkg::ROW_START_P4);
        endcase
      end
    end
  end

  always_comb begin
    pixels_left_nxt = pixels_left_r;
    row_nxt         = row_r;
    pass_nxt        = pass_r;
    col_nxt         = col_r;
    zero_base_nxt   = zero_base_r;
    fw_nxt          = fw_r;
    ox_nxt          = ox_r;
    if (accept) begin
      if (in_mode == gipw_pkg::MODE_START) begin
        pixels_left_nxt = cfg.image_width;
        row_nxt         = cfg.offset_y[COORD_BITS-1:0];
        pass_nxt        = cfg.interlaced ? gipw_pkg::PASS_1 : gipw_pkg::PASS_NORMAL;
        col_nxt         = '0;
        zero_base_nxt   = 1'b0;
        fw_nxt          = cfg.frame_width;
        ox_nxt          = cfg.offset_x;
      end else if (done) begin
        pixels_left_nxt = cfg.image_width;
        row_nxt         = r_sum[COORD_BITS-1:0];
        pass_nxt        = p_step;
        col_nxt         = '0;
        zero_base_nxt   = 1'b0;
        fw_nxt          = cfg.frame_width;
        ox_nxt          = cfg.offset_x;
      end else begin
        pixels_left_nxt = pixels_left_r - 1'b1;
        col_nxt         = col_r + 1'b1;
      end
    end
  end

  always_comb begin
    ctl_in.start     = (in_mode == gipw_pkg::MODE_START);
    ctl_in.we        = !(cfg.transparency_enable && in_pixel == cfg.transparent_index);
    ctl_in.data      = in_pixel;
    ctl_in.done      = done;
    ctl_in.zero_base = zero_base_r;
    v1_nxt           = en1 ? accept : v1_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pixels_left_r <= '0;
      row_r         <= '0;
      pass_r        <= gipw_pkg::PASS_NORMAL;
      col_r         <= '0;
      zero_base_r   <= 1'b1;
      fw_r          <= gipw_pkg::CFG_W'(1);
      ox_r          <= '0;
      v1_r          <= 1'b0;
    end else begin
      pixels_left_r <= pixels_left_nxt;
      row_r         <= row_nxt;
      pass_r        <= pass_nxt;
      col_r         <= col_nxt;
      zero_base_r   <= zero_base_nxt;
      fw_r          <= fw_nxt;
      ox_r          <= ox_nxt;
      v1_r          <= v1_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      ctl1_r <= ctl_in;
      row1_r <= row_r;
      col1_r <= col_r;
      fw1_r  <= fw_r;
      ox1_r  <= ox_r;
    end
  end

  assign s1_valid = v1_r;
  assign s1_ctl   = ctl1_r;
  assign s1_row   = row1_r;
  assign s1_col   = col1_r;
  assign s1_fw    = fw1_r;
  assign s1_ox    = ox1_r;

endmodule

@@ rtl/gipw_addr.sv @@
// ----------------------------------------------------------------------------
// gipw_addr
// Address pipeline: row times frame width, then base plus column, result reg.
// ----------------------------------------------------------------------------
module gipw_addr #(
  parameter int COORD_BITS = gipw_pkg::COORD_BITS_DEF,
  parameter int ADDR_BITS  = gipw_pkg::ADDR_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              s1_valid,
  input  gipw_pkg::item_ctl_t               s1_ctl,
  input  logic [COORD_BITS-1:0]             s1_row,
  input  logic [ADDR_BITS-1:0]              s1_col,
  input  logic [gipw_pkg::CFG_W-1:0]        s1_fw,
  input  logic [gipw_pkg::CFG_W-1:0]        s1_ox,
  output logic                              take,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_write_enable,
  output logic [gipw_pkg::OUT_ADDR_W-1:0]   out_write_address,
  output logic [gipw_pkg::PIX_W-1:0]        out_write_data,
  output logic                              out_row_done,
  output logic [gipw_pkg::OUT_ROW_W-1:0]    out_row_number
);

  localparam int PW = COORD_BITS + gipw_pkg::CFG_W;

  logic                    en2, en3;
  logic                    v2_r, v2_nxt, v3_r, v3_nxt;
  gipw_pkg::item_ctl_t     ctl2_r;
  logic [COORD_BITS-1:0]   row2_r;
  logic [ADDR_BITS-1:0]    col2_r, oc2_r;
  logic [PW-1:0]           prod2_r;
  logic [ADDR_BITS-1:0]    addr3;

  logic                              we3_r, done3_r;
  logic [gipw_pkg::OUT_ADDR_W-1:0]   addr3_r;
  logic [gipw_pkg::PIX_W-1:0]        data3_r;
  logic [gipw_pkg::OUT_ROW_W-1:0]    row3_r;

  assign en3  = !v3_r || out_ready;
  assign en2  = !v2_r || en3;
  assign take = en2;

  always_comb begin
    v2_nxt = en2 ? s1_valid : v2_r;
    v3_nxt = en3 ? v2_r : v3_r;
    // before the first start or row end the address counts up from zero
    addr3  = ctl2_r.zero_base ? col2_r : (ADDR_BITS'(prod2_r) + oc2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v2_r <= v2_nxt;
      v3_r <= v3_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (en2 && s1_valid) begin
      ctl2_r  <= s1_ctl;
      row2_r  <= s1_row;
      col2_r  <= s1_col;
      prod2_r <= PW'(s1_row) * PW'(s1_fw);
      oc2_r   <= s1_col + ADDR_BITS'(s1_ox);
    end
  end

  always_ff @(posedge clk) begin
    if (en3 && v2_r) begin
      if (ctl2_r.start) begin
        we3_r   <= 1'b0;
        addr3_r <= '0;
        data3_r <= '0;
        done3_r <= 1'b0;
        row3_r  <= '0;
      end else begin
        we3_r   <= ctl2_r.we;
        addr3_r <= gipw_pkg::OUT_ADDR_W'(addr3);
        data3_r <= ctl2_r.data;
        done3_r <= ctl2_r.done;
        row3_r  <= gipw_pkg::OUT_ROW_W'(row2_r);
      end
    end
  end

  assign out_valid         = v3_r;
  assign out_write_enable  = we3_r;
  assign out_write_address = addr3_r;
  assign out_write_data    = data3_r;
  assign out_row_done      = done3_r;
  assign out_row_number    = row3_r;

endmodule

@@ rtl/gif_interlaced_pixel_writer.sv @@
// ----------------------------------------------------------------------------
// gif_interlaced_pixel_writer
// Turns decoded GIF palette indices into frame-buffer writes.
// ----------------------------------------------------------------------------
// Takes one request per clock while the result side keeps ready high, and
// gives one result per request. The figure of one per clock comes from the
// position registers (row, pass, pixel count and column), which work out the
// next pixel's position combinationally, using adds and compares only; the
// row times frame width product sits in its own
// pipeline stage behind them. A start request (mode 0) reloads the position
// from the configuration and yields an all-zero result. Transparent pixels
// still advance the position but come out with write_enable low. Addresses
// are offsets from the buffer start; the frame width and x offset of a row
// are the ones in force at the start request or row end that began it.
// Write configuration only while idle.
module gif_interlaced_pixel_writer #(
  parameter int COORD_BITS = gipw_pkg::COORD_BITS_DEF,
  parameter int ADDR_BITS  = gipw_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  gipw_in_if.sink                        in_ch,
  gipw_out_if.source                     out_ch,
  input  logic                           cfg_we,
  input  logic [gipw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gipw_pkg::CFG_W-1:0]     cfg_wdata
);

  gipw_pkg::cfg_t              cfg;
  logic                        take, s1_valid;
  gipw_pkg::item_ctl_t         s1_ctl;
  logic [COORD_BITS-1:0]       s1_row;
  logic [ADDR_BITS-1:0]        s1_col;
  logic [gipw_pkg::CFG_W-1:0]  s1_fw, s1_ox;

  gipw_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  gipw_pos #(
    .COORD_BITS (COORD_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_pos (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg      (cfg),
    .in_valid (in_ch.valid),
    .in_mode  (in_ch.mode),
    .in_pixel (in_ch.pixel_index),
    .in_ready (in_ch.ready),
    .take     (take),
    .s1_valid (s1_valid),
    .s1_ctl   (s1_ctl),
    .s1_row   (s1_row),
    .s1_col   (s1_col),
    .s1_fw    (s1_fw),
    .s1_ox    (s1_ox)
  );

  gipw_addr #(
    .COORD_BITS (COORD_BITS),
    .ADDR_BITS  (ADDR_BITS)
  ) u_addr (
    .clk               (clk),
    .rst_n             (rst_n),
    .s1_valid          (s1_valid),
    .s1_ctl            (s1_ctl),
    .s1_row            (s1_row),
    .s1_col            (s1_col),
    .s1_fw             (s1_fw),
    .s1_ox             (s1_ox),
    .take              (take),
    .out_valid         (out_ch.valid),
    .out_ready         (out_ch.ready),
    .out_write_enable  (out_ch.write_enable),
    .out_write_address (out_ch.write_address),
    .out_write_data    (out_ch.write_data),
    .out_row_done      (out_ch.row_done),
    .out_row_number    (out_ch.row_number)
  );

endmodule

@@ rtl/gipw_checker.sv @@
// ----------------------------------------------------------------------------
// gipw_checker
// Port-level checks on the pixel writer, bound to the top level.
// ----------------------------------------------------------------------------
module gipw_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready
);

  // nothing comes out in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a free output side never stalls the input
  a_no_bubble: assert property (@(posedge clk) disable iff (!rst_n)
    out_ready |-> in_ready)
    else $error("input stalled while output is ready");

  // an accepted request reaches the output when the sink keeps up
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) ##1 out_ready ##1 out_ready |=> out_valid)
    else $error("result late");

endmodule

bind gif_interlaced_pixel_writer gipw_checker u_gipw_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready)
);
